FILE: sv/small_turing_machine_runner_top_defines.svh
// Assertion macros shared by the small Turing machine runner RTL.
// Included by the top level; relies on no other file.
`ifndef SMALL_TURING_MACHINE_RUNNER_TOP_DEFINES_SVH
`define SMALL_TURING_MACHINE_RUNNER_TOP_DEFINES_SVH

// Same-cycle implication, checked only outside reset.
`define STMR_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked only outside reset.
`define STMR_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: sv/stmr_pkg.sv
// Shared types and constants for the small Turing machine runner.
// Used by the controller, the datapath and the top level; depends on nothing.
`default_nettype none

package stmr_pkg;

    localparam int NUM_W        = 22;
    localparam int DIGITS       = 6;
    localparam int DIGIT_W      = 4;
    localparam int DIGIT_IDX_W  = 3;
    localparam int RADIX        = 12;
    localparam int MSTATE_W     = 2;
    localparam int MSTATE_MAX   = 2;
    localparam int DIR_BIT      = 0;
    localparam int SYM_BIT      = 1;

    // Quotient by twelve as (v * RECIP) >> RECIP_SHIFT, exact for all 22-bit v.
    localparam int RECIP_W      = 22;
    localparam logic [RECIP_W-1:0] RECIP = 22'd2796203;
    localparam int RECIP_SHIFT  = 25;
    localparam int PROD_W       = NUM_W + RECIP_W;

    localparam int STEPS_W      = 6;
    localparam int LEN_W        = 6;
    localparam int BITS_W       = 33;
    localparam int S_TDATA_W    = 24;
    localparam int M_TDATA_W    = 48;
    localparam int M_TUSER_W    = 1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DECODE,
        ST_RUN,
        ST_DONE
    } ctrl_state_t;

    typedef struct packed {
        logic load_item;
        logic decode_step;
        logic run_step;
        logic load_result;
    } ctrl_cmd_t;

    typedef struct packed {
        logic decode_last;
        logic halt_now;
        logic last_step;
        logic out_free;
    } dp_status_t;

endpackage

`default_nettype wire

FILE: sv/stmr_ctrl.sv
// Sequencer for the small Turing machine runner: accept, decode, run, report.
// Depends on stmr_pkg for the state type and the command and status structs.
`default_nettype none

module stmr_ctrl (
    input  wire                 aclk,
    input  wire                 aresetn,
    input  wire                 s_tvalid,
    output logic                s_tready,
    input  stmr_pkg::dp_status_t status,
    output stmr_pkg::ctrl_cmd_t cmd
);
    import stmr_pkg::*;

    ctrl_state_t state_reg;
    ctrl_state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    state_next = ST_DECODE;
                end
            end
            ST_DECODE: begin
                if (status.decode_last) begin
                    state_next = ST_RUN;
                end
            end
            ST_RUN: begin
                if (status.halt_now || status.last_step) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (status.out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        s_tready        = 1'b0;
        cmd             = '0;
        case (state_reg)
            ST_IDLE: begin
                s_tready      = 1'b1;
                cmd.load_item = s_tvalid;
            end
            ST_DECODE: begin
                cmd.decode_step = 1'b1;
            end
            ST_RUN: begin
                cmd.run_step = 1'b1;
            end
            ST_DONE: begin
                cmd.load_result = status.out_free;
            end
            default: begin
                s_tready = 1'b0;
            end
        endcase
    end

endmodule

`default_nettype wire

FILE: sv/stmr_dpath.sv
// Datapath of the small Turing machine runner: digit decoder, transition
// table, tape register, head and step counters, and the result register.
// Depends on stmr_pkg for constants and the command and status structs.
`default_nettype none

module stmr_dpath #(
    parameter int STEP_LIMIT = 32,
    parameter int TAPE_CELLS = 33
) (
    input  wire                              aclk,
    input  wire                              aresetn,
    input  wire  [stmr_pkg::S_TDATA_W-1:0]   s_tdata,
    input  stmr_pkg::ctrl_cmd_t              cmd,
    output stmr_pkg::dp_status_t             status,
    output logic                             m_tvalid,
    input  wire                              m_tready,
    output logic [stmr_pkg::M_TDATA_W-1:0]   m_tdata,
    output logic [stmr_pkg::M_TUSER_W-1:0]   m_tuser
);
    import stmr_pkg::*;

    localparam int POS_W     = $clog2(TAPE_CELLS);
    localparam int STEP_W    = $clog2(STEP_LIMIT + 1);
    localparam int BITS_KEEP = (TAPE_CELLS < BITS_W) ? TAPE_CELLS : BITS_W;
    localparam logic [POS_W-1:0]  POS_LAST  = POS_W'(TAPE_CELLS - 1);
    localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(STEP_LIMIT - 1);

    // Decoder
    logic [NUM_W-1:0]       num_reg;
    logic [DIGIT_IDX_W-1:0] digit_idx_reg;
    logic [DIGIT_W-1:0]     trans_reg [DIGITS];
    logic [PROD_W-1:0]      prod;
    logic [NUM_W-1:0]       quot;
    logic [NUM_W-1:0]       rem_full;

    // Machine
    logic [TAPE_CELLS-1:0]  tape_reg;
    logic [POS_W-1:0]       pos_reg;
    logic [POS_W-1:0]       maxpos_reg;
    logic [MSTATE_W-1:0]    mstate_reg;
    logic [STEP_W-1:0]      step_reg;
    logic                   halt_reg;
    logic [MSTATE_W-1:0]    st_clamped;
    logic                   rd_bit;
    logic [DIGIT_IDX_W-1:0] trans_idx;
    logic [DIGIT_W-1:0]     digit;
    logic [POS_W-1:0]       pos_right;

    // Result
    logic [POS_W:0]         len_full;
    logic [BITS_W-1:0]      bits_masked;
    logic                   m_tvalid_reg;
    logic                   out_halted_reg;
    logic [STEPS_W-1:0]     out_steps_reg;
    logic [LEN_W-1:0]       out_len_reg;
    logic [BITS_W-1:0]      out_bits_reg;

    assign prod     = {{RECIP_W{1'b0}}, num_reg} * {{NUM_W{1'b0}}, RECIP};
    assign quot     = NUM_W'(prod[PROD_W-1:RECIP_SHIFT]);
    assign rem_full = num_reg - (quot << 3) - (quot << 2);

    assign st_clamped = (mstate_reg > MSTATE_W'(MSTATE_MAX)) ? MSTATE_W'(MSTATE_MAX)
                                                             : mstate_reg;
    assign rd_bit     = tape_reg[pos_reg];
    assign trans_idx  = {st_clamped, rd_bit};
    assign digit      = trans_reg[trans_idx];
    // The head stays on the rightmost cell when asked to move past it.
    assign pos_right  = (pos_reg == POS_LAST) ? pos_reg : pos_reg + POS_W'(1);

    assign status.decode_last = (digit_idx_reg == DIGIT_IDX_W'(DIGITS - 1));
    assign status.halt_now    = digit[DIR_BIT] && (pos_reg == '0);
    assign status.last_step   = (step_reg == STEP_LAST);
    assign status.out_free    = !m_tvalid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (cmd.load_item) begin
            num_reg       <= s_tdata[NUM_W-1:0];
            digit_idx_reg <= '0;
        end else if (cmd.decode_step) begin
            trans_reg[digit_idx_reg] <= rem_full[DIGIT_W-1:0];
            num_reg                  <= quot;
            digit_idx_reg            <= digit_idx_reg + DIGIT_IDX_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_item) begin
            tape_reg   <= '0;
            pos_reg    <= '0;
            maxpos_reg <= '0;
            mstate_reg <= '0;
            step_reg   <= '0;
            halt_reg   <= 1'b0;
        end else if (cmd.run_step) begin
            tape_reg[pos_reg] <= digit[SYM_BIT];
            mstate_reg        <= digit[DIGIT_W-1:2];
            step_reg          <= step_reg + STEP_W'(1);
            if (status.halt_now) begin
                halt_reg <= 1'b1;
            end else if (digit[DIR_BIT]) begin
                pos_reg <= pos_reg - POS_W'(1);
            end else begin
                pos_reg <= pos_right;
                if (pos_right > maxpos_reg) begin
                    maxpos_reg <= pos_right;
                end
            end
        end
    end

    assign len_full = {1'b0, maxpos_reg} + (POS_W + 1)'(1);

    always_comb begin
        bits_masked = '0;
        for (int i = 0; i < BITS_KEEP; i++) begin
            bits_masked[i] = halt_reg && tape_reg[i] && (i < int'(len_full));
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (cmd.load_result) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_result) begin
            out_halted_reg <= halt_reg;
            out_steps_reg  <= halt_reg ? STEPS_W'(step_reg) : '0;
            out_len_reg    <= halt_reg ? LEN_W'(len_full) : '0;
            out_bits_reg   <= bits_masked;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = out_halted_reg;
    assign m_tdata  = {(M_TDATA_W - BITS_W - LEN_W - STEPS_W)'(0),
                       out_bits_reg, out_len_reg, out_steps_reg};

endmodule

`default_nettype wire

FILE: sv/small_turing_machine_runner_top.sv
// Top level of the small Turing machine runner: controller plus datapath.
// Depends on stmr_pkg, stmr_ctrl, stmr_dpath and the defines header.
//
// Channel | Dir | Payload
// s_      | in  | tdata[21:0] machine_number
// m_      | out | tuser[0] halted; tdata[5:0] step_count, [11:6] tape_length,
//         |     | [44:12] tape_bits
//
// An item is accepted, split into six base-12 digits (one digit per cycle
// through a reciprocal multiplier), run for up to STEP_LIMIT machine steps,
// and its result loaded into the result register.
// Reset is synchronous and active low; it empties the result register and
// returns the sequencer to idle. A stalled result holds the block before it
// takes the next item.
`default_nettype none
`include "small_turing_machine_runner_top_defines.svh"

module small_turing_machine_runner_top #(
    parameter int STEP_LIMIT = 32,
    parameter int TAPE_CELLS = 33
) (
    input  wire                              aclk,
    input  wire                              aresetn,
    input  wire                              s_tvalid,
    output logic                             s_tready,
    // [21:0] machine_number
    input  wire  [stmr_pkg::S_TDATA_W-1:0]   s_tdata,
    output logic                             m_tvalid,
    input  wire                              m_tready,
    // [5:0] step_count, [11:6] tape_length, [44:12] tape_bits
    output logic [stmr_pkg::M_TDATA_W-1:0]   m_tdata,
    // [0] halted
    output logic [stmr_pkg::M_TUSER_W-1:0]   m_tuser
);
    import stmr_pkg::*;

    ctrl_cmd_t  cmd;
    dp_status_t status;

    stmr_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    stmr_dpath #(
        .STEP_LIMIT (STEP_LIMIT),
        .TAPE_CELLS (TAPE_CELLS)
    ) u_dpath (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tdata  (s_tdata),
        .cmd      (cmd),
        .status   (status),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    // A machine that never halted reports an all-zero payload.
    `STMR_ASSERT_NOW(a_no_halt_zero, aclk, aresetn, m_tvalid && !m_tuser[0], m_tdata == '0, "non-halting result carries data")
    // A halting result has taken at least one step, no more than the limit, and left a tape.
    `STMR_ASSERT_NOW(a_halt_range, aclk, aresetn, m_tvalid && m_tuser[0], (m_tdata[5:0] != 6'd0) && (m_tdata[5:0] <= 6'(STEP_LIMIT)) && (m_tdata[11:6] != 6'd0), "halting result out of range")
    // Only one machine is in flight: the input closes after each transaction.
    `STMR_ASSERT_NEXT(a_one_in_flight, aclk, aresetn, s_tvalid && s_tready, !s_tready, "second item accepted while running")

endmodule

`default_nettype wire
